@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/bas_pkg.sv @@
// Types and constants of the breakpoint address set.
`timescale 1ns / 1ps

package bas_pkg;

  localparam int ADDR_W  = 20;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] ST_MISS = 2'd0;
  localparam logic [STAT_W-1:0] ST_HIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ENCODE,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic compare;
    logic append;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ design/bas_if.sv @@
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps

interface bas_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [bas_pkg::FUNC_W-1:0] func;
  logic [bas_pkg::ADDR_W-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink (input valid, input func, input address, output ready);
endinterface

interface bas_res_if;
  logic                       valid;
  logic                       ready;
  logic [bas_pkg::STAT_W-1:0]  status;
  logic [bas_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);
endinterface

@@ design/bas_cell.sv @@
// One storage cell of the address list with its own compare and shift logic.
`timescale 1ns / 1ps

module bas_cell #(
  parameter int INDEX     = 0,
  parameter int ADDR_BITS = 20,
  parameter int CNT_W     = 5,
  parameter int IDX_W     = 4
) (
  input  logic                clk,
  input  bas_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    count,
  input  logic [IDX_W-1:0]    pos,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [ADDR_BITS-1:0] neighbor,
  output logic [ADDR_BITS-1:0] entry,
  output logic                match
);

  logic occupied;

  assign occupied = CNT_W'(INDEX) < count;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= occupied && (entry == addr);
    end
    if (ctrl.append && (count == CNT_W'(INDEX))) begin
      entry <= addr;
    end else if (ctrl.shift && (IDX_W'(INDEX) >= pos)) begin
      entry <= neighbor;
    end
  end

endmodule

@@ design/breakpoint_address_set.sv @@
// Breakpoint address set: a packed list of addresses held in a row of cells.
`timescale 1ns / 1ps

// Each command word adds, removes or looks up one address (any other function
// code changes nothing) and gives one result word. After acceptance the cells
// compare the address in parallel, the match vector is encoded to a hit flag
// and a position, and then the row appends, shifts down or stays as the result
// is registered. The next command is taken the cycle after the result is
// registered, so a word is finished before the next is accepted; the result
// register lets a command be accepted while the previous result still waits
// to be taken. If that result is still not taken when the next one is ready,
// the block holds in its last step until the result register frees up.
module breakpoint_address_set #(
  parameter int CAPACITY  = 16,
  parameter int ADDR_BITS = 20
) (
  input logic      clk,
  input logic      rst,
  bas_cmd_if.sink  cmd,
  bas_res_if.source res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  bas_pkg::state_t             state;
  bas_pkg::state_t             state_next;
  bas_pkg::cell_ctrl_t         ctrl;
  logic [bas_pkg::FUNC_W-1:0]  cmd_func;
  logic [ADDR_BITS-1:0]        cmd_addr;
  logic [ADDR_BITS+bas_pkg::ADDR_W-1:0] addr_ext;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [CNT_W+bas_pkg::COUNT_W-1:0] count_ext;
  logic [CAPACITY-1:0]         match;
  logic [ADDR_BITS-1:0]        entry [CAPACITY];
  logic                        hit;
  logic                        hit_enc;
  logic [IDX_W-1:0]            pos;
  logic [IDX_W-1:0]            pos_enc;
  logic                        fire;
  logic                        accept;
  logic                        res_valid;
  logic [bas_pkg::STAT_W-1:0]  res_status;
  logic [bas_pkg::STAT_W-1:0]  status_next;
  logic [bas_pkg::COUNT_W-1:0] res_count;

  assign accept   = cmd.valid && cmd.ready;
  assign addr_ext = {{ADDR_BITS{1'b0}}, cmd.address};
  assign count_ext = {{bas_pkg::COUNT_W{1'b0}}, count_next};

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.entry_count = res_count;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    bas_cell #(
      .INDEX    (k),
      .ADDR_BITS(ADDR_BITS),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (count),
      .pos     (pos),
      .addr    (cmd_addr),
      .neighbor(entry[(k + 1 < CAPACITY) ? k + 1 : k]),
      .entry   (entry[k]),
      .match   (match[k])
    );
  end

  // At most one cell matches, so an OR of the matching indexes is its position.
  always_comb begin
    pos_enc = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (match[k]) begin
        pos_enc = pos_enc | IDX_W'(k);
      end
    end
    hit_enc = |match;
  end

  always_comb begin
    state_next    = state;
    cmd.ready     = 1'b0;
    ctrl.compare  = 1'b0;
    ctrl.append   = 1'b0;
    ctrl.shift    = 1'b0;
    fire          = 1'b0;
    count_next    = count;
    status_next   = bas_pkg::ST_MISS;
    case (state)
      bas_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = bas_pkg::S_MATCH;
        end
      end
      bas_pkg::S_MATCH: begin
        ctrl.compare = 1'b1;
        state_next   = bas_pkg::S_ENCODE;
      end
      bas_pkg::S_ENCODE: begin
        state_next = bas_pkg::S_APPLY;
      end
      bas_pkg::S_APPLY: begin
        fire = !res_valid || res.ready;
        case (cmd_func)
          bas_pkg::FUNC_ADD: begin
            if (hit) begin
              status_next = bas_pkg::ST_MISS;
            end else if (count >= CNT_W'(CAPACITY)) begin
              status_next = bas_pkg::ST_FULL;
            end else begin
              status_next = bas_pkg::ST_HIT;
              ctrl.append = fire;
              count_next  = count + CNT_W'(1);
            end
          end
          bas_pkg::FUNC_REMOVE: begin
            if (hit) begin
              status_next = bas_pkg::ST_HIT;
              ctrl.shift  = fire;
              count_next  = count - CNT_W'(1);
            end
          end
          bas_pkg::FUNC_LOOKUP: begin
            status_next = hit ? bas_pkg::ST_HIT : bas_pkg::ST_MISS;
          end
          default: begin
            status_next = bas_pkg::ST_MISS;
          end
        endcase
        if (fire) begin
          state_next = bas_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bas_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bas_pkg::S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func <= cmd.func;
      cmd_addr <= addr_ext[ADDR_BITS-1:0];
    end
    if (state == bas_pkg::S_ENCODE) begin
      hit <= hit_enc;
      pos <= pos_enc;
    end
    if (fire) begin
      res_status <= status_next;
      res_count  <= count_ext[bas_pkg::COUNT_W-1:0];
    end
  end

endmodule

@@ design/bas_checker.sv @@
// Port-level checks for the breakpoint address set and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bas_checker #(
  parameter int CAPACITY = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [bas_pkg::STAT_W-1:0]  res_status,
  input logic [bas_pkg::COUNT_W-1:0] res_entry_count
);

  `BAS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `BAS_ASSERT_NEXT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready, !cmd_ready)
  `BAS_ASSERT_SAME(a_status_code, clk, rst, res_valid, res_status != 2'd3)
  `BAS_ASSERT_SAME(a_full_count, clk, rst, res_valid && (res_status == bas_pkg::ST_FULL),
    res_entry_count == bas_pkg::COUNT_W'(CAPACITY))

endmodule

bind breakpoint_address_set bas_checker #(
  .CAPACITY(CAPACITY)
) u_bas_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_status     (res.status),
  .res_entry_count(res.entry_count)
);

@@ bench/breakpoint_set_checker.sv @@
// Checker that predicts and compares every result word of the breakpoint address set.
`timescale 1ns / 1ps

module breakpoint_set_checker #(
  parameter int CAPACITY  = 16,
  parameter int ADDR_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  bas_cmd_if   cmd,
  bas_res_if   res,
  output int   fail_count,
  output int   pending_count
);
  import bas_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } bp_reply_t;

  logic [ADDR_BITS-1:0] bp_table [CAPACITY];
  int unsigned          bp_used;
  bp_reply_t            pending_replies [$];

  function automatic bp_reply_t step_breakpoint_table(input logic [FUNC_W-1:0] func,
                                                      input logic [ADDR_W-1:0] address);
    logic [ADDR_BITS-1:0] key;
    bp_reply_t            reply;
    int                   hit_pos;
    int                   k;
    key = ADDR_BITS'(address);
    hit_pos = -1;
    for (k = 0; k < CAPACITY; k++) begin
      if (k < bp_used && hit_pos < 0 && bp_table[k] == key) hit_pos = k;
    end
    reply.status = ST_MISS;
    case (func)
      FUNC_ADD: begin
        if (hit_pos >= 0) begin
          reply.status = ST_MISS;
        end else if (bp_used >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          bp_table[bp_used] = key;
          bp_used++;
          reply.status = ST_HIT;
        end
      end
      FUNC_REMOVE: begin
        if (hit_pos >= 0) begin
          for (k = hit_pos; k + 1 < bp_used; k++) bp_table[k] = bp_table[k + 1];
          bp_used--;
          reply.status = ST_HIT;
        end
      end
      FUNC_LOOKUP: begin
        if (hit_pos >= 0) reply.status = ST_HIT;
      end
      default: begin
      end
    endcase
    reply.entry_count = COUNT_W'(bp_used);
    return reply;
  endfunction

  always @(posedge clk) begin
    bp_reply_t want;
    if (rst) begin
      bp_used = 0;
      pending_replies.delete();
      fail_count = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_replies.size() == 0) begin
          $error("result word with no command pending: status %0d, entry_count %0d",
                 res.status, res.entry_count);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res.status);
            fail_count++;
          end
          if (res.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   res.entry_count);
            fail_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        pending_replies.push_back(step_breakpoint_table(cmd.func, cmd.address));
      end
    end
    pending_count = pending_replies.size();
  end

endmodule

@@ bench/tb_breakpoint_address_set.sv @@
// Top of the breakpoint address set testbench: clock, reset, command and result traffic.
`timescale 1ns / 1ps

module tb_breakpoint_address_set;
  import bas_pkg::*;

  localparam int                CAPACITY       = 16;
  localparam int                RANDOM_WORDS   = 1880;
  localparam int                POOL_SIZE      = 24;
  localparam int                WATCHDOG_LIMIT = 2000;
  localparam logic [FUNC_W-1:0] FUNC_NONE      = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   words_sent;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  bas_cmd_if cmd_ch ();
  bas_res_if res_ch ();

  breakpoint_address_set #(
    .CAPACITY  (CAPACITY),
    .ADDR_BITS (ADDR_W)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  breakpoint_set_checker #(
    .CAPACITY  (CAPACITY),
    .ADDR_BITS (ADDR_W)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .res           (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  function automatic int idle_len(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] address);
    int gap;
    gap = idle_len(((words_sent / 150) % 4) == 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.func    <= func;
    cmd_ch.address <= address;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_random_word(input bit filling);
    int                r;
    int                add_weight;
    int                remove_weight;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    add_weight    = filling ? 55 : 15;
    remove_weight = filling ? 15 : 50;
    r = $urandom_range(99);
    if (r < 4) func = FUNC_NONE;
    else if (r < 4 + add_weight) func = FUNC_ADD;
    else if (r < 4 + add_weight + remove_weight) func = FUNC_REMOVE;
    else func = FUNC_LOOKUP;
    if ($urandom_range(9) < 8) address = addr_pool[$urandom_range(POOL_SIZE - 1)];
    else address = ADDR_W'($urandom);
    send_word(func, address);
  endtask

  initial begin
    int k;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.func    <= FUNC_ADD;
    cmd_ch.address <= '0;
    words_sent = 0;
    for (k = 0; k < POOL_SIZE; k++) addr_pool[k] = ADDR_W'($urandom);
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(FUNC_LOOKUP, '0);
    send_word(FUNC_REMOVE, '1);
    send_word(FUNC_ADD, '0);
    send_word(FUNC_ADD, '1);
    send_word(FUNC_ADD, '0);
    send_word(FUNC_NONE, 20'h5A5A5);
    send_word(FUNC_LOOKUP, '1);
    for (k = 2; k < CAPACITY; k++) send_word(FUNC_ADD, (ADDR_W'(k) << 12) | 20'h00ABC);
    send_word(FUNC_ADD, 20'h12345);
    send_word(FUNC_ADD, '1);
    send_word(FUNC_REMOVE, '0);
    send_word(FUNC_REMOVE, 20'h0FABC);
    send_word(FUNC_REMOVE, 20'h07ABC);
    send_word(FUNC_LOOKUP, 20'h07ABC);

    for (k = 0; k < RANDOM_WORDS; k++) send_random_word(((k / 120) % 2) == 0);
    cmd_ch.valid <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_breakpoint_address_set: PASS");
    end else begin
      $display("tb_breakpoint_address_set: FAIL");
    end
    $finish;
  end

  initial begin
    int  stall;
    int  cycle;
    bit  held;
    res_ch.ready <= 1'b0;
    cycle = 0;
    held  = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && cycle >= 2000) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        cycle += 400;
      end
      stall = idle_len(((cycle / 500) % 4) == 3);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        cycle += stall;
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      cycle++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_breakpoint_address_set: FAIL");
    $finish;
  end

endmodule
